@@ rtl/lmt_pkg.sv @@
// Shared types and constants of the line minimum tree.
`default_nettype none

package lmt_pkg;

   // Request kinds
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_FULL  = 2'd1;
   localparam logic [1:0] REQ_SEG   = 2'd2;
   localparam logic [1:0] REQ_QUERY = 2'd3;

   localparam int COORD_W   = 32;
   localparam int SLOPE_W   = 32;
   localparam int ICPT_IN_W = 63;
   localparam int VALUE_W   = 64;
   localparam int NODE_DW   = SLOPE_W + VALUE_W;

   typedef logic signed [SLOPE_W-1:0] slope_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   // Empty line marker and saturation bounds
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

endpackage

`default_nettype wire

@@ rtl/lmt_ram.sv @@
// Generic single write port, single registered read port RAM.
`default_nettype none

module lmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/line_min_tree_unit.sv @@
// Top level of the line minimum tree: node store, coordinate table, sequencer.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_type, req_position, req_range_end,
//           |           |                    | req_coord_value, req_slope, req_intercept
//   rsp     | out       | rsp_valid/rsp_stall | rsp_min_value, rsp_no_line
//
// A load, or a segment with an empty range, completes on acceptance and leaves the unit idle.
// Each tree node visited by a line insert takes three coordinate reads through the single
// table port, then six line evaluations on the shared multiply and saturating add unit,
// then one decision step.
// A query walks from its leaf up to the root: one multiply and one add per level.
// After reset a clearing pass writes all 2 * TREE_LEAVES node entries empty; req_stall is high.
// A finished query waits in the output register while rsp_stall is high.
`default_nettype none

module line_min_tree_unit #(
   parameter int LEAF_COUNT = 1024,
   localparam int LEAF_W = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1,
   localparam int TREE_LEAVES = 1 << LEAF_W,
   localparam int POS_W = LEAF_W + 1,
   localparam int NODE_W = LEAF_W + 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_type,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic [POS_W-1:0]           req_range_end,
   input  wire logic signed [31:0]         req_coord_value,
   input  wire logic signed [31:0]         req_slope,
   input  wire logic signed [62:0]         req_intercept,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [63:0]              rsp_min_value,
   output logic                            rsp_no_line
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_Q_NODE = 4'd2;
   localparam logic [3:0] ST_Q_MUL  = 4'd3;
   localparam logic [3:0] ST_Q_ADD  = 4'd4;
   localparam logic [3:0] ST_Q_DONE = 4'd5;
   localparam logic [3:0] ST_P_RD0  = 4'd6;
   localparam logic [3:0] ST_P_RD1  = 4'd7;
   localparam logic [3:0] ST_P_RD2  = 4'd8;
   localparam logic [3:0] ST_P_RD3  = 4'd9;
   localparam logic [3:0] ST_P_EVAL = 4'd10;
   localparam logic [3:0] ST_P_DEC  = 4'd11;
   localparam logic [3:0] ST_S_LEFT = 4'd12;
   localparam logic [3:0] ST_S_RGT  = 4'd13;
   localparam logic [3:0] ST_S_SHFT = 4'd14;

   localparam logic [POS_W-1:0]  TL_POS  = POS_W'(TREE_LEAVES);
   localparam logic [NODE_W-1:0] TL_NODE = NODE_W'(TREE_LEAVES);
   localparam logic [2:0]        EV_LAST = 3'd6;

   // Control registers
   logic [3:0]        state_ff, state_in, ret_ff, ret_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Walk registers
   logic [NODE_W-1:0] k_ff, k_in;
   logic [POS_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [POS_W-1:0]  l0_ff, l0_in, r0_ff, r0_in, len_ff, len_in;
   logic [NODE_W:0]   sl_ff, sl_in, sr_ff, sr_in;
   logic [2:0]        ev_ff, ev_in, cmp_ff, cmp_in;

   // Operand and result registers
   lmt_pkg::slope_type ws_ff, ws_in, os_ff, os_in, ls_ff, ls_in;
   lmt_pkg::value_type wb_ff, wb_in, ob_ff, ob_in, lb_ff, lb_in, nb_ff, nb_in;
   lmt_pkg::coord_type xl_ff, xl_in, xm_ff, xm_in, xr_ff, xr_in, qx_ff, qx_in;
   lmt_pkg::value_type prod_ff, prod_in, newv_ff, newv_in, best_ff, best_in;
   logic               none_ff, none_in;
   lmt_pkg::value_type rsp_min_ff, rsp_min_in;
   logic               rsp_none_ff, rsp_none_in;

   // Memory ports
   logic                         c_we;
   logic [POS_W-1:0]             c_waddr, c_raddr;
   logic [lmt_pkg::COORD_W-1:0]  c_wdata, c_rdata;
   logic                         n_we;
   logic [NODE_W-1:0]            n_waddr, n_raddr;
   logic [lmt_pkg::NODE_DW-1:0]  n_wdata, n_rdata;

   // Shared arithmetic unit
   lmt_pkg::slope_type mul_s;
   lmt_pkg::coord_type mul_x;
   lmt_pkg::value_type add_b, sat_v;
   logic signed [64:0] sum_v;
   logic [2:0]         add_idx;

   logic              accept;
   logic [POS_W:0]    mid_sum;
   logic [POS_W-1:0]  mid, seg_end, r0_dec;
   logic [NODE_W:0]   sr_dec;
   logic              bl, bm, br;

   lmt_ram #(.WIDTH(lmt_pkg::COORD_W), .DEPTH(TREE_LEAVES + 1)) u_coord_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   lmt_ram #(.WIDTH(lmt_pkg::NODE_DW), .DEPTH(2 * TREE_LEAVES)) u_node_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_waddr),
      .wr_data (n_wdata),
      .rd_addr (n_raddr),
      .rd_data (n_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[POS_W:1];
   assign seg_end = (req_range_end > TL_POS) ? TL_POS : req_range_end;
   assign sr_dec  = sr_ff - (NODE_W+1)'(1);
   assign r0_dec  = r0_ff - len_ff;
   assign bl      = cmp_ff[0];
   assign bm      = cmp_ff[1];
   assign br      = cmp_ff[2];

   // Select multiply and add operands (query node, or one of six line evaluations), saturate the sum
   always_comb begin
      add_idx = ev_ff - 3'd1;
      if (state_ff == ST_Q_MUL) begin
         mul_s = n_rdata[lmt_pkg::NODE_DW-1:lmt_pkg::VALUE_W];
         mul_x = qx_ff;
      end else begin
         mul_s = ev_ff[0] ? os_ff : ws_ff;
         unique case (ev_ff[2:1])
            2'd0:    mul_x = xl_ff;
            2'd1:    mul_x = xm_ff;
            default: mul_x = xr_ff;
         endcase
      end
      prod_in = lmt_pkg::value_type'(mul_s) * lmt_pkg::value_type'(mul_x);
      add_b   = (state_ff == ST_Q_ADD) ? nb_ff : (add_idx[0] ? ob_ff : wb_ff);
      sum_v   = {prod_ff[63], prod_ff} + {add_b[63], add_b};
      if (sum_v[64] != sum_v[63]) begin
         sat_v = sum_v[64] ? lmt_pkg::VALUE_MIN : lmt_pkg::VALUE_MAX;
      end else begin
         sat_v = sum_v[63:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  clr_in = clr_ff;
      k_in = k_ff;  lo_in = lo_ff;  hi_in = hi_ff;
      l0_in = l0_ff;  r0_in = r0_ff;  len_in = len_ff;  sl_in = sl_ff;  sr_in = sr_ff;
      ev_in = ev_ff;  cmp_in = cmp_ff;
      ws_in = ws_ff;  wb_in = wb_ff;  os_in = os_ff;  ob_in = ob_ff;
      ls_in = ls_ff;  lb_in = lb_ff;  nb_in = nb_ff;
      xl_in = xl_ff;  xm_in = xm_ff;  xr_in = xr_ff;  qx_in = qx_ff;
      newv_in = newv_ff;  best_in = best_ff;  none_in = none_ff;
      rsp_min_in = rsp_min_ff;  rsp_none_in = rsp_none_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      c_we = 1'b0;  c_waddr = req_position;  c_wdata = req_coord_value;
      c_raddr = req_position;
      n_we = 1'b0;  n_waddr = k_ff;  n_wdata = {ws_ff, wb_ff};
      n_raddr = k_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            n_we    = 1'b1;
            n_waddr = clr_ff;
            n_wdata = {lmt_pkg::SLOPE_W'(0), lmt_pkg::VALUE_MAX};
            clr_in  = clr_ff + NODE_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  lmt_pkg::REQ_LOAD: begin
                     c_we = (req_position <= TL_POS);
                  end
                  lmt_pkg::REQ_FULL: begin
                     ws_in = req_slope;
                     wb_in = {req_intercept[62], req_intercept};
                     k_in = NODE_W'(1);  lo_in = '0;  hi_in = TL_POS;
                     ret_in = ST_IDLE;  state_in = ST_P_RD0;
                  end
                  lmt_pkg::REQ_SEG: begin
                     if (req_position < seg_end) begin
                        ls_in = req_slope;
                        lb_in = {req_intercept[62], req_intercept};
                        sl_in = {1'b0, req_position} + (NODE_W+1)'(TREE_LEAVES);
                        sr_in = {1'b0, seg_end} + (NODE_W+1)'(TREE_LEAVES);
                        l0_in = req_position;  r0_in = seg_end;  len_in = POS_W'(1);
                        state_in = ST_S_LEFT;
                     end
                  end
                  lmt_pkg::REQ_QUERY: begin
                     best_in = lmt_pkg::VALUE_MAX;
                     none_in = 1'b1;
                     if (req_position < TL_POS) begin
                        k_in = req_position[NODE_W-1:0] + TL_NODE;
                        state_in = ST_Q_NODE;
                     end else begin
                        state_in = ST_Q_DONE;
                     end
                  end
               endcase
            end
         end
         ST_Q_NODE: begin
            qx_in    = c_rdata;
            state_in = ST_Q_MUL;
         end
         ST_Q_MUL: begin
            nb_in    = n_rdata[lmt_pkg::VALUE_W-1:0];
            none_in  = none_ff && (n_rdata[lmt_pkg::VALUE_W-1:0] == lmt_pkg::VALUE_MAX);
            state_in = ST_Q_ADD;
         end
         ST_Q_ADD: begin
            if (sat_v < best_ff) begin
               best_in = sat_v;
            end
            k_in    = k_ff >> 1;
            n_raddr = k_ff >> 1;
            state_in = ((k_ff >> 1) == '0) ? ST_Q_DONE : ST_Q_MUL;
         end
         ST_Q_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = best_ff;
               rsp_none_in  = none_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_P_RD0: begin
            c_raddr  = lo_ff;
            state_in = ST_P_RD1;
         end
         ST_P_RD1: begin
            xl_in    = c_rdata;
            os_in    = n_rdata[lmt_pkg::NODE_DW-1:lmt_pkg::VALUE_W];
            ob_in    = n_rdata[lmt_pkg::VALUE_W-1:0];
            c_raddr  = mid;
            state_in = ST_P_RD2;
         end
         ST_P_RD2: begin
            xm_in    = c_rdata;
            c_raddr  = hi_ff;
            state_in = ST_P_RD3;
         end
         ST_P_RD3: begin
            xr_in    = c_rdata;
            ev_in    = '0;
            state_in = ST_P_EVAL;
         end
         ST_P_EVAL: begin
            // Even evaluations are the new line, odd ones the stored line
            if (ev_ff != '0) begin
               if (add_idx[0]) begin
                  cmp_in[add_idx[2:1]] = (newv_ff < sat_v);
               end else begin
                  newv_in = sat_v;
               end
            end
            ev_in = ev_ff + 3'd1;
            if (ev_ff == EV_LAST) begin
               state_in = ST_P_DEC;
            end
         end
         ST_P_DEC: begin
            if (!bl && !br) begin
               state_in = ret_ff;
            end else if (bl && br) begin
               n_we     = 1'b1;
               state_in = ret_ff;
            end else begin
               // Keep the winner at the middle, push the other one down
               if (bm) begin
                  n_we  = 1'b1;
                  ws_in = os_ff;
                  wb_in = ob_ff;
               end
               if ((hi_ff - lo_ff) == POS_W'(1)) begin
                  state_in = ret_ff;
               end else if (bl != bm) begin
                  k_in = {k_ff[NODE_W-2:0], 1'b0};
                  hi_in = mid;
                  state_in = ST_P_RD0;
               end else begin
                  k_in = {k_ff[NODE_W-2:0], 1'b1};
                  lo_in = mid;
                  state_in = ST_P_RD0;
               end
            end
         end
         ST_S_LEFT: begin
            if (sl_ff >= sr_ff) begin
               state_in = ST_IDLE;
            end else if (sl_ff[0]) begin
               k_in = sl_ff[NODE_W-1:0];  lo_in = l0_ff;  hi_in = l0_ff + len_ff;
               ws_in = ls_ff;  wb_in = lb_ff;
               sl_in = sl_ff + (NODE_W+1)'(1);  l0_in = l0_ff + len_ff;
               ret_in = ST_S_RGT;  state_in = ST_P_RD0;
            end else begin
               state_in = ST_S_RGT;
            end
         end
         ST_S_RGT: begin
            if (sr_ff[0]) begin
               k_in = sr_dec[NODE_W-1:0];  lo_in = r0_dec;  hi_in = r0_ff;
               ws_in = ls_ff;  wb_in = lb_ff;
               sr_in = sr_dec;  r0_in = r0_dec;
               ret_in = ST_S_SHFT;  state_in = ST_P_RD0;
            end else begin
               state_in = ST_S_SHFT;
            end
         end
         ST_S_SHFT: begin
            sl_in    = sl_ff >> 1;
            sr_in    = sr_ff >> 1;
            len_in   = len_ff << 1;
            state_in = ST_S_LEFT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_IDLE;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      k_ff <= k_in;  lo_ff <= lo_in;  hi_ff <= hi_in;
      l0_ff <= l0_in;  r0_ff <= r0_in;  len_ff <= len_in;  sl_ff <= sl_in;  sr_ff <= sr_in;
      ev_ff <= ev_in;  cmp_ff <= cmp_in;
      ws_ff <= ws_in;  wb_ff <= wb_in;  os_ff <= os_in;  ob_ff <= ob_in;
      ls_ff <= ls_in;  lb_ff <= lb_in;  nb_ff <= nb_in;
      xl_ff <= xl_in;  xm_ff <= xm_in;  xr_ff <= xr_in;  qx_ff <= qx_in;
      prod_ff <= prod_in;  newv_ff <= newv_in;  best_ff <= best_in;  none_ff <= none_in;
      rsp_min_ff <= rsp_min_in;  rsp_none_ff <= rsp_none_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_no_line   = rsp_none_ff;

endmodule

`default_nettype wire

@@ rtl/lmt_checker.sv @@
// Port checker of the line minimum tree and its bind to the top level.
`default_nettype none

module lmt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_type,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_min_value,
   input wire logic        rsp_no_line
);

   // Reset starts the clearing pass with no result pending
   a_reset_stalls: assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("request side open or result pending after reset");

   // A full line insert or a query keeps the unit busy afterwards
   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_type == lmt_pkg::REQ_FULL || req_type == lmt_pkg::REQ_QUERY)) |=> req_stall)
      else $error("unit ready right after a multi cycle transaction");

   // An empty path always reports the largest value
   a_empty_is_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_line) |-> (rsp_min_value == lmt_pkg::VALUE_MAX))
      else $error("no line flagged with a value other than the largest");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_min_value) && $stable(rsp_no_line))
      else $error("stalled result changed");

endmodule

bind line_min_tree_unit lmt_checker u_lmt_checker (.*);

`default_nettype wire
